FILE: sv/keypoint_greedy_nms_top_defines.svh
// ---------------------------------------------------------------------------
// keypoint_greedy_nms_top_defines
// Assertion macros for the keypoint suppression block.
// ---------------------------------------------------------------------------
`ifndef KEYPOINT_GREEDY_NMS_TOP_DEFINES_SVH
`define KEYPOINT_GREEDY_NMS_TOP_DEFINES_SVH

`ifndef SYNTH
// checked only outside reset
`define KGN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define KGN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KGN_ASSERT(lbl, prop, msg)
`define KGN_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/kgn_pkg.sv
// ---------------------------------------------------------------------------
// kgn_pkg
// Types and constants shared by the keypoint suppression block.
// ---------------------------------------------------------------------------
package kgn_pkg;

  localparam int CALC_W = 14;

  typedef enum logic [2:0] {
    STAT_ACCEPTED   = 3'd0,
    STAT_BELOW      = 3'd1,
    STAT_BORDER     = 3'd2,
    STAT_SUPPRESSED = 3'd3,
    STAT_LIMIT      = 3'd4,
    STAT_CLEARED    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CFG_THRESHOLD  = 3'd0,
    CFG_RADIUS     = 3'd1,
    CFG_MAX_POINTS = 3'd2,
    CFG_WIDTH      = 3'd3,
    CFG_HEIGHT     = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CHECK,
    ST_LOOKUP,
    ST_FILL,
    ST_FLUSH,
    ST_CLEAR,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic        mode;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [15:0] score;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [9:0]  point_index;
    logic [9:0]  out_x;
    logic [9:0]  out_y;
    logic [15:0] out_score;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic check;
    logic lookup;
    logic fill_step;
    logic clr_step;
    logic res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic pre_rej;
    logic hit;
    logic fill_last;
    logic clr_last;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: sv/kgn_ctrl.sv
// ---------------------------------------------------------------------------
// kgn_ctrl
// Sequencer: map clearing sweep, candidate check, window fill, result hand-off.
// ---------------------------------------------------------------------------
module kgn_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kgn_pkg::dp_sts_t   sts_i,
  output kgn_pkg::ctrl_cmd_t cmd_o
);
  import kgn_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = sts_i.is_clear ? ST_CLEAR : ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = (sts_i.pre_rej || sts_i.hit) ? ST_RESULT : ST_FILL;
      end
      ST_FILL: begin
        if (sts_i.fill_last) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_d = ST_RESULT;
      end
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_INIT: begin
        cmd_o.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_CHECK: begin
        cmd_o.check = !sts_i.is_clear;
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      ST_RESULT: begin
        cmd_o.res_load = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: sv/kgn_datapath.sv
// ---------------------------------------------------------------------------
// kgn_datapath
// Config registers, row-wide flag memory, candidate checks, output register.
// ---------------------------------------------------------------------------
module kgn_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  kgn_pkg::in_item_t  in_data_i,
  output kgn_pkg::out_item_t out_data_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  kgn_pkg::ctrl_cmd_t cmd_i,
  output kgn_pkg::dp_sts_t   sts_o
);
  import kgn_pkg::*;

  localparam int AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // configuration
  logic [15:0] thr_q;
  logic [2:0]  radius_q;
  logic [9:0]  max_pts_q;
  logic [10:0] width_q;
  logic [10:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= 16'd512;
      radius_q  <= 3'd4;
      max_pts_q <= 10'd500;
      width_q   <= 11'd640;
      height_q  <= 11'd480;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD:  thr_q     <= cfg_data_i;
        CFG_RADIUS:     radius_q  <= cfg_data_i[2:0];
        CFG_MAX_POINTS: max_pts_q <= cfg_data_i[9:0];
        CFG_WIDTH:      width_q   <= cfg_data_i[10:0];
        CFG_HEIGHT:     height_q  <= cfg_data_i[10:0];
        default: begin
        end
      endcase
    end
  end

  // item and per-item state
  in_item_t              item_q;
  status_e               status_q;
  logic [MAX_WIDTH-1:0]  mask_q;
  logic [AW-1:0]         row_q;
  logic [AW-1:0]         row_end_q;
  logic [AW-1:0]         wr_row_q;
  logic                  wr_en_q;
  logic [MAX_WIDTH-1:0]  rdata_q;
  logic [AW-1:0]         clr_row_q;
  logic [9:0]            count_q;
  out_item_t             out_q;
  logic                  out_valid_q;

  logic [MAX_WIDTH-1:0]  map_mem [MAX_HEIGHT];

  // effective geometry
  logic [CALC_W-1:0] r_w, two_r, w_w, h_w, x_w, y_w, lo_x, lo_y, hi_y;
  logic [CALC_W-1:0] rad_ext, wid_ext, hgt_ext;
  logic              border, below, limit;
  status_e           pre_status;
  logic [MAX_WIDTH-1:0] base_mask;
  logic [XW-1:0]     x_idx;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;

  assign rad_ext = CALC_W'(radius_q);
  assign wid_ext = CALC_W'(width_q);
  assign hgt_ext = CALC_W'(height_q);
  assign r_w   = (rad_ext > CALC_W'(MAX_RADIUS)) ? CALC_W'(MAX_RADIUS) : rad_ext;
  assign two_r = r_w + r_w;
  assign w_w   = (wid_ext > CALC_W'(MAX_WIDTH)) ? CALC_W'(MAX_WIDTH) : wid_ext;
  assign h_w   = (hgt_ext > CALC_W'(MAX_HEIGHT)) ? CALC_W'(MAX_HEIGHT) : hgt_ext;
  assign x_w   = CALC_W'(item_q.pos_x);
  assign y_w   = CALC_W'(item_q.pos_y);
  assign lo_x  = x_w - r_w;
  assign lo_y  = y_w - r_w;
  assign hi_y  = y_w + r_w;
  assign x_idx = x_w[XW-1:0];

  assign border = (w_w <= two_r) || (h_w <= two_r) || (x_w < r_w) ||
                  (x_w + r_w >= w_w) || (y_w < r_w) || (y_w + r_w >= h_w);
  assign below  = item_q.score < thr_q;
  assign limit  = count_q >= max_pts_q;

  always_comb begin
    if (below) begin
      pre_status = STAT_BELOW;
    end else if (limit) begin
      pre_status = STAT_LIMIT;
    end else if (border) begin
      pre_status = STAT_BORDER;
    end else begin
      pre_status = STAT_ACCEPTED;
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_WIDTH; j++) begin
      base_mask[j] = (CALC_W'(j) <= two_r);
    end
  end

  assign rd_en   = cmd_i.check || cmd_i.fill_step;
  assign rd_addr = cmd_i.check ? y_w[AW-1:0] : row_q;

  // flag memory: one row per word
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= map_mem[rd_addr];
    end
    if (cmd_i.clr_step) begin
      map_mem[clr_row_q] <= '0;
    end else if (wr_en_q) begin
      map_mem[wr_row_q] <= rdata_q | mask_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.check) begin
      status_q  <= pre_status;
      mask_q    <= base_mask << lo_x;
      row_q     <= lo_y[AW-1:0];
      row_end_q <= hi_y[AW-1:0];
    end else if (cmd_i.fill_step) begin
      row_q <= row_q + AW'(1);
    end
    if (cmd_i.lookup && (status_q == STAT_ACCEPTED) && rdata_q[x_idx]) begin
      status_q <= STAT_SUPPRESSED;
    end
    wr_row_q <= row_q;
    if (cmd_i.res_load) begin
      if (!item_q.mode) begin
        out_q <= '{status: STAT_CLEARED, point_index: '0, out_x: '0, out_y: '0,
                   out_score: '0};
      end else begin
        out_q.status      <= status_q;
        out_q.point_index <= (status_q == STAT_ACCEPTED) ? count_q : '0;
        out_q.out_x       <= item_q.pos_x;
        out_q.out_y       <= item_q.pos_y;
        out_q.out_score   <= item_q.score;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_en_q     <= 1'b0;
      clr_row_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_en_q <= cmd_i.fill_step;
      if (cmd_i.clr_step) begin
        clr_row_q <= sts_o.clr_last ? '0 : clr_row_q + AW'(1);
      end
      if (cmd_i.res_load) begin
        if (!item_q.mode) begin
          count_q <= '0;
        end else if (status_q == STAT_ACCEPTED) begin
          count_q <= count_q + 10'd1;
        end
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.is_clear  = !item_q.mode;
  assign sts_o.pre_rej   = status_q != STAT_ACCEPTED;
  assign sts_o.hit       = rdata_q[x_idx];
  assign sts_o.fill_last = row_q == row_end_q;
  assign sts_o.clr_last  = clr_row_q == AW'(MAX_HEIGHT - 1);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/keypoint_greedy_nms_top.sv
// ---------------------------------------------------------------------------
// keypoint_greedy_nms_top
// Greedy keypoint suppression over a one-bit flag map, one row per memory word.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one word per item: a clear
// word (mode 0) or a candidate (x, y, score) in falling score order.
// Output channel (out_valid_o / out_stall_i) returns one word per item.
// Config port (cfg_valid_i / cfg_ready_o) is always ready; write only while
// the block is idle.
// Items are handled one at a time; the row-wide flag memory sets the pace.
// A candidate rejected by threshold, limit, border or flag skips the window fill:
// its result is loaded after the lookup, then the block goes idle for the next word.
// Accepted candidate: one memory read-modify-write per window row, then a flush.
// Clear word: one row cleared per cycle over all MAX_HEIGHT rows.
// After reset the block clears all MAX_HEIGHT rows of the map, stalling input.
// The result sits in an output register; a stalled receiver holds it, and the
// block keeps working on the next word until its own result is due.
module keypoint_greedy_nms_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kgn_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kgn_pkg::out_item_t out_data_o
);
  import kgn_pkg::*;

  `include "keypoint_greedy_nms_top_defines.svh"

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready_o = 1'b1;

  kgn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kgn_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  `KGN_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "not busy after accept")
  `KGN_ASSERT_ALWAYS(a_one_writer, !(cmd.clr_step && cmd.fill_step), "clear and fill overlap")
  `KGN_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(cmd.res_load), "result without load")

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the greedy keypoint suppression block.
// Sorted candidate frames with random content (plus some noise) are fed over
// the stall handshake. Each word is predicted at acceptance by a local model
// of the flag map and point count. Results are checked in order, field by
// field. Register settings change between drained phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import kgn_pkg::*;

  localparam int MAP_W          = 1024;
  localparam int MAP_H          = 1024;
  localparam int RAD_LIMIT      = 7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_ITEMS    = 170;
  localparam int PRINT_CAP      = 30;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index   = '0;
  logic [15:0] cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data     = '0;
  logic        out_valid_o;
  logic        out_stall   = 1'b0;
  out_item_t   out_data_o;

  keypoint_greedy_nms_top #(
    .MAX_WIDTH (MAP_W),
    .MAX_HEIGHT(MAP_H),
    .MAX_RADIUS(RAD_LIMIT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of the block state and registers
  bit [MAP_W-1:0] flag_rows [MAP_H];
  logic [9:0]     pts_in_frame = '0;
  logic [15:0]    nms_thr      = 16'd512;
  logic [2:0]     nms_radius   = 3'd4;
  logic [9:0]     nms_max_pts  = 10'd500;
  logic [10:0]    nms_width    = 11'd640;
  logic [10:0]    nms_height   = 11'd480;

  in_item_t  nms_pending [$];
  out_item_t nms_expected [$];

  int send_idle_pct = 35;
  int recv_idle_pct = 67;
  int hold_reqs     = 0;
  int hold_seen;
  int hold_left;
  int err_count     = 0;
  int results_seen  = 0;
  int items_queued  = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;
  int status_tally [6];

  function automatic out_item_t predict_nms(input in_item_t w);
    out_item_t      res;
    int             r, wd, ht, xx, yy;
    bit             on_border;
    bit [MAP_W-1:0] win_mask;
    res = '0;
    if (w.mode == 1'b0) begin
      foreach (flag_rows[i]) flag_rows[i] = '0;
      pts_in_frame = '0;
      res.status = STAT_CLEARED;
      return res;
    end
    r  = (nms_radius > RAD_LIMIT) ? RAD_LIMIT : nms_radius;
    wd = (nms_width > MAP_W) ? MAP_W : nms_width;
    ht = (nms_height > MAP_H) ? MAP_H : nms_height;
    xx = int'(w.pos_x);
    yy = int'(w.pos_y);
    on_border = (wd <= 2 * r) || (ht <= 2 * r) || (xx < r) || (xx > wd - r - 1) ||
                (yy < r) || (yy > ht - r - 1);
    res.out_x     = w.pos_x;
    res.out_y     = w.pos_y;
    res.out_score = w.score;
    if (w.score < nms_thr) begin
      res.status = STAT_BELOW;
    end else if (pts_in_frame >= nms_max_pts) begin
      res.status = STAT_LIMIT;
    end else if (on_border) begin
      res.status = STAT_BORDER;
    end else if (flag_rows[yy][xx]) begin
      res.status = STAT_SUPPRESSED;
    end else begin
      res.status      = STAT_ACCEPTED;
      res.point_index = pts_in_frame;
      pts_in_frame    = pts_in_frame + 10'd1;
      win_mask = ((MAP_W'(1) << (2 * r + 1)) - MAP_W'(1)) << (xx - r);
      for (int row = yy - r; row <= yy + r; row++) begin
        flag_rows[row] = flag_rows[row] | win_mask;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= PRINT_CAP) begin
      $display("MISMATCH result %0d %s: got %0h want %0h", results_seen, what, got, want);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (nms_expected.size() == 0) begin
      report_mismatch("with no word pending", 32'(got.status), 0);
      return;
    end
    want = nms_expected.pop_front();
    results_seen++;
    status_tally[want.status]++;
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.point_index !== want.point_index)
      report_mismatch("point_index", 32'(got.point_index), 32'(want.point_index));
    if (got.out_x !== want.out_x)
      report_mismatch("out_x", 32'(got.out_x), 32'(want.out_x));
    if (got.out_y !== want.out_y)
      report_mismatch("out_y", 32'(got.out_y), 32'(want.out_y));
    if (got.out_score !== want.out_score)
      report_mismatch("out_score", 32'(got.out_score), 32'(want.out_score));
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall_o) nms_expected = {nms_expected, predict_nms(in_data)};
      if (!in_valid || !in_stall_o) begin
        if (nms_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= nms_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_seen = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall) check_result(out_data_o);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (nms_pending.size() != 0 || in_valid || nms_expected.size() != 0);
  endtask

  task automatic write_cfg_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_THRESHOLD:  nms_thr     = val;
      CFG_RADIUS:     nms_radius  = val[2:0];
      CFG_MAX_POINTS: nms_max_pts = val[9:0];
      CFG_WIDTH:      nms_width   = val[10:0];
      CFG_HEIGHT:     nms_height  = val[10:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int thr, input int rad, input int maxp,
                                input int wd, input int ht);
    wait_drained();
    repeat (8) @(posedge clk_i);
    write_cfg_reg(CFG_THRESHOLD, 16'(thr));
    write_cfg_reg(CFG_RADIUS, 16'(rad));
    write_cfg_reg(CFG_MAX_POINTS, 16'(maxp));
    write_cfg_reg(CFG_WIDTH, 16'(wd));
    write_cfg_reg(CFG_HEIGHT, 16'(ht));
    settings_used++;
  endtask

  task automatic push_clear();
    in_item_t w;
    w = '0;
    nms_pending = {nms_pending, w};
    items_queued++;
  endtask

  task automatic push_cand(input int x, input int y, input int sc);
    in_item_t w;
    w.mode  = 1'b1;
    w.pos_x = 10'(x);
    w.pos_y = 10'(y);
    w.score = 16'(sc);
    nms_pending = {nms_pending, w};
    items_queued++;
  endtask

  // one frame of score-sorted candidates, mostly well formed
  task automatic gen_frame(input int n_cand, input bit with_clear);
    int x, y, sc, rr, wd, ht, pick, px, py;
    rr = (nms_radius > RAD_LIMIT) ? RAD_LIMIT : nms_radius;
    wd = (nms_width > MAP_W) ? MAP_W : nms_width;
    ht = (nms_height > MAP_H) ? MAP_H : nms_height;
    sc = $urandom_range(0, 65535);
    px = $urandom_range(0, wd - 1);
    py = $urandom_range(0, ht - 1);
    if (with_clear) push_clear();
    for (int k = 0; k < n_cand; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        if ($urandom_range(0, 15) == 0) push_clear();
        else push_cand($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 65535));
      end else begin
        if (pick < 40) begin
          x = px + int'($urandom_range(0, 2 * rr + 2)) - (rr + 1);
          y = py + int'($urandom_range(0, 2 * rr + 2)) - (rr + 1);
        end else if (pick < 50) begin
          case ($urandom_range(0, 3))
            0: x = rr - 1;
            1: x = rr;
            2: x = wd - rr - 1;
            default: x = wd - rr;
          endcase
          y = $urandom_range(0, ht - 1);
          if ($urandom_range(0, 1) == 1) begin
            px = x;
            x  = y;
            y  = px;
          end
        end else begin
          x = $urandom_range(0, wd - 1);
          y = $urandom_range(0, ht - 1);
        end
        x  = (x < 0) ? 0 : ((x > 1023) ? 1023 : x);
        y  = (y < 0) ? 0 : ((y > 1023) ? 1023 : y);
        px = x;
        py = y;
        sc = sc - int'($urandom_range(0, 1500));
        if (sc < 0) sc = 0;
        push_cand(x, y, sc);
      end
    end
  endtask

  task automatic random_phase();
    int phase_start;
    phase_start = items_queued;
    while (items_queued - phase_start < PHASE_ITEMS) gen_frame($urandom_range(8, 50), 1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values: accept, suppress, border edges, threshold edge
    push_clear();
    push_cand(100, 100, 65535);
    push_cand(100, 100, 60000);
    push_cand(104, 104, 50000);
    push_cand(105, 100, 50000);
    push_cand(3, 200, 40000);
    push_cand(4, 200, 40000);
    push_cand(635, 300, 39000);
    push_cand(636, 300, 39000);
    push_cand(300, 3, 38000);
    push_cand(300, 475, 38000);
    push_cand(300, 476, 38000);
    push_cand(1023, 1023, 37000);
    push_cand(500, 300, 512);
    push_cand(500, 200, 511);
    push_cand(0, 0, 0);

    // limit of one point; threshold checked ahead of limit, limit ahead of border
    apply_settings(512, 4, 1, 640, 480);
    push_clear();
    push_cand(200, 200, 1000);
    push_cand(300, 300, 1000);
    push_cand(0, 0, 1000);
    push_cand(5, 5, 100);
    // raise limit mid-frame: the last point still flagged its window
    apply_settings(512, 4, 1023, 640, 480);
    push_cand(202, 202, 900);
    apply_settings(512, 4, 0, 640, 480);
    push_cand(300, 300, 900);
    // image narrower than the window
    apply_settings(512, 4, 1023, 8, 480);
    push_cand(4, 4, 900);
    // oversized image, zero radius, zero threshold
    apply_settings(0, 0, 1023, 2047, 2047);
    push_cand(1023, 1023, 0);
    push_cand(0, 0, 0);
    push_cand(0, 0, 0);
    apply_settings(65535, 0, 1023, 2047, 2047);
    push_cand(10, 10, 65534);
    push_cand(10, 10, 65535);

    // random part
    apply_settings(512, 4, 500, 640, 480);
    random_phase();
    hold_reqs++;
    apply_settings(0, 7, 1023, 1024, 1024);
    random_phase();

    send_idle_pct = 67;
    recv_idle_pct = 35;
    apply_settings($urandom_range(0, 20000), $urandom_range(0, 2), 5,
                   $urandom_range(16, 1024), $urandom_range(16, 1024));
    gen_frame(30, 1'b1);
    wait_drained();
    gen_frame(30, 1'b0);
    random_phase();
    apply_settings(30000, 3, 200, 2047, 2047);
    random_phase();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(0, 7, 1, 16, 16);
    random_phase();
    apply_settings($urandom_range(0, 65535), $urandom_range(0, 7), $urandom_range(1, 1023),
                   $urandom_range(16, 1024), $urandom_range(16, 1024));
    random_phase();

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (nms_expected.size() != 0) report_mismatch("words never answered",
                                                  nms_expected.size(), 0);
    $display("Sent %0d words under %0d register settings, checked %0d results",
             items_queued, settings_used, results_seen);
    $display("Outcomes: %0d accepted, %0d below, %0d border, %0d suppressed, %0d limit, %0d clear",
             status_tally[STAT_ACCEPTED], status_tally[STAT_BELOW], status_tally[STAT_BORDER],
             status_tally[STAT_SUPPRESSED], status_tally[STAT_LIMIT],
             status_tally[STAT_CLEARED]);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
